// ===== hdl/wts_pkg.sv =====
// ----------------------------------------------------------------------------
// wts_pkg: shared types and constants of the weekly time switch
// Packed stamp layout, register indexes, modes and the flag groups that the
// evaluation stages pass to the decision stage.
// ----------------------------------------------------------------------------
`default_nettype none

package wts_pkg;

  // packed stamp: year12 month4 day5 hour5 minute6 second6
  localparam int unsigned StampW = 38;
  localparam int unsigned TodW   = 17;
  localparam int unsigned DaysN  = 7;
  localparam int unsigned LastDay = 6;
  localparam int unsigned WdW    = 3;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [StampW-1:0] stamp_t;
  typedef logic [TodW-1:0]   tod_t;
  typedef logic [DaysN-1:0]  mask_t;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_START_STAMP = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_END_STAMP   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MODE        = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WEEKDAY     = 3'd3;

  typedef enum logic [1:0] {
    MODE_DATE_CONT    = 2'd0,
    MODE_DATE_INTER   = 2'd1,
    MODE_WEEKDAY_CONT = 2'd2,
    MODE_WEEKDAY_INTER = 2'd3
  } mode_e;

  // results of the moment and time-of-day compares
  typedef struct packed {
    logic in_range;     // start <= now < end
    logic tod_ge_start; // now tod >= start tod
    logic tod_lt_end;   // now tod <  end tod
    logic wraps;        // daily window passes midnight
  } cmp_flags_t;

  // weekday run facts for the current day
  typedef struct packed {
    logic in_run;   // today belongs to a run
    logic is_first; // today is the first day of its run
    logic is_last;  // today is the last day of its run
    logic prev_on;  // yesterday is enabled
  } day_flags_t;

endpackage

`default_nettype wire

// ===== hdl/wts_time_cmp.sv =====
// ----------------------------------------------------------------------------
// wts_time_cmp: moment and time-of-day compare stage
// Compares the packed current moment against the start and end stamps and
// registers the resulting flags.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_time_cmp (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wts_pkg::stamp_t   now_i,
  input  wts_pkg::stamp_t   start_stamp_i,
  input  wts_pkg::stamp_t   end_stamp_i,
  output wts_pkg::cmp_flags_t flags_o
);

  wts_pkg::tod_t       tod_now;
  wts_pkg::tod_t       tod_start;
  wts_pkg::tod_t       tod_end;
  wts_pkg::cmp_flags_t flags_d;
  wts_pkg::cmp_flags_t flags_q;

  assign tod_now   = now_i[wts_pkg::TodW-1:0];
  assign tod_start = start_stamp_i[wts_pkg::TodW-1:0];
  assign tod_end   = end_stamp_i[wts_pkg::TodW-1:0];

  // chronological order is plain unsigned order of the packed words
  always_comb begin
    flags_d.in_range     = (now_i >= start_stamp_i) && (now_i < end_stamp_i);
    flags_d.tod_ge_start = (tod_now >= tod_start);
    flags_d.tod_lt_end   = (tod_now < tod_end);
    flags_d.wraps        = (tod_start > tod_end);
  end

  // flag register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  assign flags_o = flags_q;

endmodule

`default_nettype wire

// ===== hdl/wts_day_flags.sv =====
// ----------------------------------------------------------------------------
// wts_day_flags: weekday run decode stage
// Finds where the current weekday sits in the runs of enabled days, with a
// Saturday run and a Sunday run merged into one that wraps.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_day_flags (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire [wts_pkg::WdW-1:0]    weekday_i,
  input  wts_pkg::mask_t            mask_i,
  output wts_pkg::day_flags_t       flags_o
);

  logic                     merged;
  logic [7:0]               run_vec;
  logic [7:0]               first_vec;
  logic [7:0]               last_vec;
  logic [wts_pkg::WdW-1:0]  prev_day;
  wts_pkg::day_flags_t      flags_d;
  wts_pkg::day_flags_t      flags_q;

  // both ends enabled with a gap somewhere: two runs join across the week end
  assign merged = mask_i[0] && mask_i[wts_pkg::LastDay] && (mask_i != '1);

  // weekday seven only lands inside a wrapping run, never on its edges
  assign run_vec = {merged, mask_i};

  always_comb begin
    first_vec    = '0;
    last_vec     = '0;
    first_vec[0] = mask_i[0] && !merged;
    for (int d = 1; d < wts_pkg::DaysN; d++) begin
      first_vec[d] = mask_i[d] && !mask_i[d-1];
    end
    for (int d = 0; d < wts_pkg::DaysN - 1; d++) begin
      last_vec[d] = mask_i[d] && !mask_i[d+1];
    end
    last_vec[wts_pkg::LastDay] = mask_i[wts_pkg::LastDay] && !merged;
  end

  // Sunday looks back to Saturday, as does weekday seven
  assign prev_day = (weekday_i == '0) ? wts_pkg::WdW'(wts_pkg::LastDay)
                                       : weekday_i - 1'b1;

  always_comb begin
    flags_d.in_run   = run_vec[weekday_i];
    flags_d.is_first = first_vec[weekday_i];
    flags_d.is_last  = last_vec[weekday_i];
    flags_d.prev_on  = run_vec[prev_day];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  assign flags_o = flags_q;

endmodule

`default_nettype wire

// ===== hdl/wts_decide.sv =====
// ----------------------------------------------------------------------------
// wts_decide: mode select and output stage
// Combines the compare and weekday flags under the operating mode and drives
// the registered result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_decide (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  valid_i,
  input  wts_pkg::mode_e       mode_i,
  input  wts_pkg::cmp_flags_t  cmp_i,
  input  wts_pkg::day_flags_t  day_i,
  output logic                 done_o,
  output logic                 switch_on_o
);

  logic daily;
  logic on_d;
  logic done_q;
  logic on_q;

  // daily window, open across midnight when it wraps
  assign daily = cmp_i.wraps ? (cmp_i.tod_ge_start || cmp_i.tod_lt_end)
                             : (cmp_i.tod_ge_start && cmp_i.tod_lt_end);

  always_comb begin
    case (mode_i)
      wts_pkg::MODE_DATE_CONT:    on_d = cmp_i.in_range;
      wts_pkg::MODE_DATE_INTER:   on_d = cmp_i.in_range && daily;
      wts_pkg::MODE_WEEKDAY_CONT: begin
        on_d = day_i.in_run &&
               (cmp_i.tod_ge_start || !day_i.is_first) &&
               (cmp_i.tod_lt_end || !day_i.is_last);
      end
      wts_pkg::MODE_WEEKDAY_INTER: begin
        if (cmp_i.wraps) begin
          on_d = (cmp_i.tod_ge_start && day_i.in_run) ||
                 (cmp_i.tod_lt_end && day_i.prev_on);
        end else begin
          on_d = day_i.in_run && daily;
        end
      end
      default: on_d = 1'b0;
    endcase
  end

  // output beat, level held low between beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      on_q   <= 1'b0;
    end else begin
      done_q <= valid_i;
      on_q   <= valid_i && on_d;
    end
  end

  assign done_o      = done_q;
  assign switch_on_o = on_q;

endmodule

`default_nettype wire

// ===== hdl/weekly_time_switch.sv =====
// ----------------------------------------------------------------------------
// weekly_time_switch: programmable weekly time switch
// Decides from the current calendar time whether the scheduled output is on.
//
//   channel   handshake                 payload
//   input     start_i / busy_o          now_second_i .. now_weekday_i
//   result    done_o (strobe)           switch_on_o
//   config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One beat is taken every cycle; busy_o stays low.
// The result passes in order through the input register, the compare and
// weekday decode stage, and the mode select and output register.
// The result strobe lasts one cycle and cannot be held off.
// Reset clears the stage valids and all configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module weekly_time_switch (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  wire [5:0]                    now_second_i,
  input  wire [5:0]                    now_minute_i,
  input  wire [4:0]                    now_hour_i,
  input  wire [4:0]                    now_day_i,
  input  wire [3:0]                    now_month_i,
  input  wire [11:0]                   now_year_i,
  input  wire [2:0]                    now_weekday_i,
  output logic                         done_o,
  output logic                         switch_on_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [wts_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire [wts_pkg::StampW-1:0]    cfg_data_i
);

  wts_pkg::stamp_t      start_stamp_q;
  wts_pkg::stamp_t      end_stamp_q;
  wts_pkg::mode_e       mode_q;
  wts_pkg::mask_t       mask_q;
  logic                 cfg_we;

  logic                 s1_valid_q;
  wts_pkg::stamp_t      s1_now_q;
  logic [wts_pkg::WdW-1:0] s1_wd_q;
  logic                 s2_valid_q;
  wts_pkg::cmp_flags_t  s2_cmp;
  wts_pkg::day_flags_t  s2_day;
  logic                 accept;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_stamp_q <= '0;
      end_stamp_q   <= '0;
      mode_q        <= wts_pkg::MODE_DATE_CONT;
      mask_q        <= '0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        wts_pkg::CFG_START_STAMP: start_stamp_q <= cfg_data_i;
        wts_pkg::CFG_END_STAMP:   end_stamp_q   <= cfg_data_i;
        wts_pkg::CFG_MODE:        mode_q <= wts_pkg::mode_e'(cfg_data_i[1:0]);
        wts_pkg::CFG_WEEKDAY:     mask_q <= cfg_data_i[wts_pkg::DaysN-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: capture the packed moment
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_now_q <= {now_year_i, now_month_i, now_day_i, now_hour_i, now_minute_i,
                 now_second_i};
    s1_wd_q  <= now_weekday_i;
  end

  // stage 2: compares and weekday decode side by side
  wts_time_cmp u_time_cmp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .now_i         (s1_now_q),
    .start_stamp_i (start_stamp_q),
    .end_stamp_i   (end_stamp_q),
    .flags_o       (s2_cmp)
  );

  wts_day_flags u_day_flags (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .weekday_i (s1_wd_q),
    .mask_i    (mask_q),
    .flags_o   (s2_day)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // stage 3: mode select and result beat
  wts_decide u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s2_valid_q),
    .mode_i      (mode_q),
    .cmp_i       (s2_cmp),
    .day_i       (s2_day),
    .done_o      (done_o),
    .switch_on_o (switch_on_o)
  );

endmodule

`default_nettype wire

// ===== hdl/wts_checker.sv =====
// ----------------------------------------------------------------------------
// wts_checker: port-level checks of the weekly time switch
// Watches the fixed latency between input and result beats, the idle
// level of the result and the config handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_checker (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  input  wire                        busy_o,
  input  wire                        done_o,
  input  wire                        switch_on_o,
  input  wire                        cfg_valid_i,
  input  wire                        cfg_ready_o
);

  // never refuses an input beat
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

  // every result traces back to an accepted input beat
  a_done_has_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start_i, 3) && !$past(busy_o, 3)))
    else $error("result without input beat");

  // every beat taken out of reset gives its result
  a_beat_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) ##1 rst_ni ##1 rst_ni |=> done_o)
    else $error("input beat lost");

  // result level stays low between strobes
  a_idle_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> !switch_on_o)
    else $error("switch_on outside a result beat");

  // a config beat is always taken at once
  a_cfg_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config beat held off");

endmodule

bind weekly_time_switch wts_checker u_wts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .switch_on_o (switch_on_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire

// ===== sim/tb_weekly_time_switch.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_weekly_time_switch: self-checking bench for the weekly time switch
// Programs start/end stamps, mode and weekday mask through the config
// channel. It then feeds calendar samples and checks every switch_on result
// against a local model of the schedule. A directed pass covers the stamp
// edges, the daily window wrap, merged weekend runs and weekday seven.
// Random passes follow, with reconfiguration between blocks of samples.
// ----------------------------------------------------------------------------

module tb_weekly_time_switch;
  import wts_pkg::*;

  localparam int ResultLatency = 3;
  localparam int TimeoutNs     = 2_000_000;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_FIRST = 3'd4;

  localparam logic [WdW-1:0] WD_SUN    = 3'd0;
  localparam logic [WdW-1:0] WD_MON    = 3'd1;
  localparam logic [WdW-1:0] WD_TUE    = 3'd2;
  localparam logic [WdW-1:0] WD_WED    = 3'd3;
  localparam logic [WdW-1:0] WD_FRI    = 3'd5;
  localparam logic [WdW-1:0] WD_SAT    = 3'd6;
  localparam logic [WdW-1:0] WD_BEYOND = 3'd7;

  typedef struct packed {
    stamp_t         now;
    logic [WdW-1:0] weekday;
    logic           on;
  } pending_switch_t;

  // DUT connections
  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [5:0]         now_second_i;
  logic [5:0]         now_minute_i;
  logic [4:0]         now_hour_i;
  logic [4:0]         now_day_i;
  logic [3:0]         now_month_i;
  logic [11:0]        now_year_i;
  logic [2:0]         now_weekday_i;
  logic               done_o;
  logic               switch_on_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  stamp_t             cfg_data_i;

  // local copy of the schedule registers
  stamp_t sched_start;
  stamp_t sched_end;
  mode_e  sched_mode;
  mask_t  sched_mask;

  pending_switch_t pending_switch_q[$];
  pending_switch_t checked_entry;
  int              error_count;
  int              sender_idle_pct;

  weekly_time_switch DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .now_second_i  (now_second_i),
    .now_minute_i  (now_minute_i),
    .now_hour_i    (now_hour_i),
    .now_day_i     (now_day_i),
    .now_month_i   (now_month_i),
    .now_year_i    (now_year_i),
    .now_weekday_i (now_weekday_i),
    .done_o        (done_o),
    .switch_on_o   (switch_on_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // schedule model
  // ---------------------------------------------------------------------------

  // index of the first run holding the day, -1 if none; runs wrap when first > last
  function automatic int run_holding(int n_runs, logic [11:0] firsts, logic [11:0] lasts,
                                     logic [WdW-1:0] day);
    int             hit;
    logic [WdW-1:0] f;
    logic [WdW-1:0] l;
    hit = -1;
    for (int i = 0; i < n_runs && i < 4; i++) begin
      f = firsts[i*3 +: 3];
      l = lasts[i*3 +: 3];
      if (hit < 0) begin
        if (f > l) begin
          if (day >= f || day <= l) hit = i;
        end else if (day >= f && day <= l) begin
          hit = i;
        end
      end
    end
    return hit;
  endfunction

  function automatic logic predict_switch_on(stamp_t now, logic [WdW-1:0] wd);
    tod_t           ts;
    tod_t           te;
    tod_t           tn;
    logic           in_range;
    logic           wraps;
    logic           on;
    logic [7:0]     mask8;
    logic [11:0]    firsts;
    logic [11:0]    lasts;
    logic           open_run;
    int             n_runs;
    int             seg;
    int             seg_prev;
    logic [WdW-1:0] prev;
    logic           prev_on;
    ts = sched_start[TodW-1:0];
    te = sched_end[TodW-1:0];
    tn = now[TodW-1:0];
    in_range = (now >= sched_start) && (now < sched_end);
    wraps = ts > te;
    on = 1'b0;
    case (sched_mode)
      MODE_DATE_CONT: on = in_range;
      MODE_DATE_INTER: begin
        on = in_range && (wraps ? (tn >= ts || tn < te) : (tn >= ts && tn < te));
      end
      default: begin
        // split the mask into runs of enabled days
        mask8 = {1'b0, sched_mask};
        firsts = '0;
        lasts = '0;
        open_run = 1'b0;
        n_runs = 0;
        for (int d = 0; d < DaysN; d++) begin
          if (!open_run && mask8[d]) begin
            open_run = 1'b1;
            firsts[(n_runs & 3)*3 +: 3] = 3'(d);
          end
          if (open_run && !mask8[d+1]) begin
            open_run = 1'b0;
            lasts[(n_runs & 3)*3 +: 3] = 3'(d);
            n_runs++;
          end
        end
        // a Saturday run and a Sunday run join across the week boundary
        if (n_runs > 1 && lasts[((n_runs - 1) & 3)*3 +: 3] == 3'(LastDay) &&
            firsts[2:0] == WD_SUN) begin
          n_runs--;
          firsts[2:0] = firsts[(n_runs & 3)*3 +: 3];
        end
        seg = run_holding(n_runs, firsts, lasts, wd);
        if (sched_mode == MODE_WEEKDAY_CONT) begin
          if (seg >= 0) begin
            on = (tn >= ts || wd != firsts[(seg & 3)*3 +: 3]) &&
                 (tn < te || wd != lasts[(seg & 3)*3 +: 3]);
          end
        end else begin
          prev = (wd == WD_SUN) ? WD_SAT : wd - 3'd1;
          seg_prev = -1;
          if (seg < 0 && wraps) seg_prev = run_holding(n_runs, firsts, lasts, prev);
          prev_on = sched_mask[prev];
          if (seg >= 0 || seg_prev >= 0) begin
            if (wraps) on = (tn >= ts && seg >= 0) || (tn < te && prev_on);
            else       on = tn >= ts && tn < te;
          end
        end
      end
    endcase
    return on;
  endfunction

  // ---------------------------------------------------------------------------
  // shared helpers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("%0t ns  MISMATCH  %s", $time, msg);
    error_count++;
  endtask

  function automatic stamp_t pack_stamp(logic [11:0] yr, logic [3:0] mon, logic [4:0] day,
                                        logic [4:0] hr, logic [5:0] mi, logic [5:0] se);
    return {yr, mon, day, hr, mi, se};
  endfunction

  // mostly plausible calendar stamps, sometimes any bit pattern
  function automatic stamp_t rand_stamp();
    if ($urandom_range(7) == 0) return stamp_t'({$urandom, $urandom});
    return pack_stamp(12'($urandom_range(4095)), 4'($urandom_range(12, 1)),
                      5'($urandom_range(31, 1)), 5'($urandom_range(23)),
                      6'($urandom_range(59)), 6'($urandom_range(59)));
  endfunction

  // lower start and wait until every pending result has come back
  task automatic hold_until_drained();
    start_i = 1'b0;
    while (pending_switch_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // one config beat, issued only with the block idle
  task automatic write_reg(logic [CfgIdxW-1:0] idx, stamp_t data);
    hold_until_drained();
    repeat (ResultLatency + 1) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_START_STAMP: sched_start = data;
      CFG_END_STAMP:   sched_end = data;
      CFG_MODE:        sched_mode = mode_e'(data[1:0]);
      CFG_WEEKDAY:     sched_mask = data[DaysN-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // unused upper bits of mode and mask words carry random junk
  task automatic configure(stamp_t st, stamp_t en, mode_e m, mask_t mk);
    stamp_t junk;
    junk = stamp_t'({$urandom, $urandom});
    write_reg(CFG_START_STAMP, st);
    write_reg(CFG_END_STAMP, en);
    write_reg(CFG_MODE, {junk[StampW-1:2], m});
    write_reg(CFG_WEEKDAY, {junk[StampW-1:DaysN], mk});
  endtask

  // one input beat; start stays high on return so back-to-back beats need no gap
  task automatic send_sample(stamp_t now, logic [WdW-1:0] wd);
    pending_switch_t entry;
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i       = 1'b1;
    now_year_i    = now[37:26];
    now_month_i   = now[25:22];
    now_day_i     = now[21:17];
    now_hour_i    = now[16:12];
    now_minute_i  = now[11:6];
    now_second_i  = now[5:0];
    now_weekday_i = wd;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    entry.now = now;
    entry.weekday = wd;
    entry.on = predict_switch_on(now, wd);
    pending_switch_q.push_back(entry);
    @(negedge clk_i);
  endtask

  // result checker: every strobe must match the oldest pending entry
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_switch_q.size() == 0) begin
        report_mismatch($sformatf("result strobe with nothing pending (switch_on %b)",
                                  switch_on_o));
      end else begin
        checked_entry = pending_switch_q.pop_front();
        if (switch_on_o !== checked_entry.on) begin
          report_mismatch($sformatf("switch_on %b, want %b (now %h weekday %0d)",
                                    switch_on_o, checked_entry.on, checked_entry.now,
                                    checked_entry.weekday));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values, every register index, spare indexes ignored
  task automatic test_register_access();
    send_sample('1, WD_BEYOND);
    configure('0, '1, MODE_DATE_CONT, 7'h7F);
    // spare indexes must not clobber the end stamp
    for (int k = 0; k < 4; k++) write_reg(CFG_SPARE_FIRST + 3'(k), '0);
    send_sample(pack_stamp(2024, 6, 15, 12, 0, 0), WD_WED);
    send_sample('0, WD_SUN);
  endtask

  // range edges, plain and wrapping daily windows
  task automatic test_date_modes();
    stamp_t st;
    stamp_t en;
    st = pack_stamp(2023, 3, 10, 8, 0, 0);
    en = pack_stamp(2023, 3, 20, 17, 30, 0);
    configure(st, en, MODE_DATE_CONT, 7'h00);
    send_sample(st - 1, WD_MON);
    send_sample(st, WD_MON);
    send_sample(en - 1, WD_MON);
    send_sample(en, WD_MON);
    write_reg(CFG_MODE, 38'(MODE_DATE_INTER));
    send_sample(pack_stamp(2023, 3, 15, 7, 59, 59), WD_WED);
    send_sample(pack_stamp(2023, 3, 15, 12, 0, 0), WD_WED);
    // overnight window 22:00 .. 06:00
    configure(pack_stamp(2023, 3, 10, 22, 0, 0), pack_stamp(2023, 3, 20, 6, 0, 0),
              MODE_DATE_INTER, 7'h00);
    send_sample(pack_stamp(2023, 3, 15, 23, 0, 0), WD_WED);
    send_sample(pack_stamp(2023, 3, 15, 12, 0, 0), WD_WED);
    send_sample(pack_stamp(2023, 3, 15, 5, 59, 59), WD_WED);
  endtask

  // weekday runs: working week, merged weekend, overnight window, empty and split masks
  task automatic test_weekday_modes();
    configure(pack_stamp(0, 1, 1, 8, 0, 0), pack_stamp(0, 1, 1, 17, 0, 0),
              MODE_WEEKDAY_CONT, 7'b0111110);
    send_sample(pack_stamp(2024, 1, 1, 7, 0, 0), WD_MON);
    send_sample(pack_stamp(2024, 1, 1, 9, 0, 0), WD_MON);
    send_sample(pack_stamp(2024, 1, 3, 3, 0, 0), WD_WED);
    send_sample(pack_stamp(2024, 1, 5, 17, 0, 0), WD_FRI);
    send_sample(pack_stamp(2024, 1, 7, 12, 0, 0), WD_SUN);
    // Saturday and Sunday join into one run across the week boundary
    write_reg(CFG_WEEKDAY, 38'(7'b1000001));
    send_sample(pack_stamp(2024, 1, 6, 9, 0, 0), WD_SAT);
    send_sample(pack_stamp(2024, 1, 7, 16, 0, 0), WD_SUN);
    send_sample(pack_stamp(2024, 1, 7, 12, 0, 0), WD_BEYOND);
    // overnight window on Monday spills into Tuesday morning
    configure(pack_stamp(0, 1, 1, 22, 0, 0), pack_stamp(0, 1, 1, 6, 0, 0),
              MODE_WEEKDAY_INTER, 7'b0000010);
    send_sample(pack_stamp(2024, 1, 2, 5, 0, 0), WD_TUE);
    send_sample(pack_stamp(2024, 1, 1, 23, 0, 0), WD_MON);
    send_sample(pack_stamp(2024, 1, 1, 5, 0, 0), WD_MON);
    write_reg(CFG_WEEKDAY, '0);
    send_sample(pack_stamp(2024, 1, 3, 12, 0, 0), WD_WED);
    configure(pack_stamp(0, 1, 1, 8, 0, 0), pack_stamp(0, 1, 1, 17, 0, 0),
              MODE_WEEKDAY_CONT, 7'b1010101);
    send_sample(pack_stamp(2024, 1, 3, 12, 0, 0), WD_BEYOND);
  endtask

  // random schedules, samples clustered around the stamps and daily edges
  task automatic test_random(int count, int idle_pct);
    int             left;
    int             block;
    stamp_t         st;
    stamp_t         en;
    stamp_t         now;
    tod_t           base_tod;
    mask_t          mk;
    logic [WdW-1:0] wd;
    sender_idle_pct = idle_pct;
    left = count;
    while (left > 0) begin
      st = rand_stamp();
      case ($urandom_range(7))
        0, 1: en = st + stamp_t'($urandom_range(1 << 18));
        2, 3: en = st + stamp_t'($urandom_range(1 << 30));
        4:    en = st - stamp_t'($urandom_range(1 << 18));
        5:    en = rand_stamp();
        6: begin
          st = '0;
          en = '1;
        end
        default: en = st;
      endcase
      case ($urandom_range(7))
        0:       mk = '0;
        1:       mk = '1;
        default: mk = mask_t'($urandom);
      endcase
      configure(st, en, mode_e'($urandom_range(3)), mk);
      if ($urandom_range(3) == 0) begin
        write_reg(CFG_SPARE_FIRST + 3'($urandom_range(3)), stamp_t'({$urandom, $urandom}));
      end
      block = $urandom_range(80, 20);
      if (block > left) block = left;
      for (int i = 0; i < block; i++) begin
        if (i == block / 2 && $urandom_range(3) == 0) hold_until_drained();
        case ($urandom_range(9))
          0, 1, 2: now = sched_start + stamp_t'($urandom_range(6)) - 38'd3;
          3, 4, 5: now = sched_end + stamp_t'($urandom_range(6)) - 38'd3;
          6, 7: begin
            now = rand_stamp();
            base_tod = $urandom_range(1) ? sched_start[TodW-1:0] : sched_end[TodW-1:0];
            now[TodW-1:0] = base_tod + tod_t'($urandom_range(6)) - 17'd3;
          end
          8:       now = rand_stamp();
          default: now = stamp_t'({$urandom, $urandom});
        endcase
        wd = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(6));
        send_sample(now, wd);
      end
      left -= block;
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    now_second_i    = '0;
    now_minute_i    = '0;
    now_hour_i      = '0;
    now_day_i       = '0;
    now_month_i     = '0;
    now_year_i      = '0;
    now_weekday_i   = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    sched_start     = '0;
    sched_end       = '0;
    sched_mode      = MODE_DATE_CONT;
    sched_mask      = '0;
    error_count     = 0;
    sender_idle_pct = 16;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_register_access();
    test_date_modes();
    test_weekday_modes();
    test_random(567, 16);
    test_random(567, 63);
    test_random(566, 0);

    hold_until_drained();
    repeat (ResultLatency + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_weekly_time_switch: done, clean");
    end else begin
      $display("tb_weekly_time_switch: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TimeoutNs);
    $display("%0t ns  TIMEOUT  %0d results still pending", $time, pending_switch_q.size());
    $display("tb_weekly_time_switch: done, errors");
    $finish;
  end

endmodule
